FILE: rtl/core/button_hold_tracker_macros.svh
// Assertion helpers shared by the tracker modules.
// Each expects clk and rst_n in scope.
`ifndef BUTTON_HOLD_TRACKER_MACROS_SVH
`define BUTTON_HOLD_TRACKER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define BHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define BHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bht_pkg.sv
`default_nettype none

package bht_pkg;

  localparam int unsigned BUTTON_COUNT = 22;
  localparam int unsigned KEYPAD_COUNT = 16;

  localparam logic [15:0] RELEASE_MARK = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFE;

  // Keypad bit 14 is active high, all others active low
  localparam logic [15:0] ACTIVE_HIGH_MASK = 16'h4000;

  localparam logic [11:0] LOW_THRESHOLD_RESET  = 12'd100;
  localparam logic [11:0] HIGH_THRESHOLD_RESET = 12'd1000;

  // Configuration register indexes
  localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;

  // Key characters
  localparam logic [6:0] KEY_ONE  = 7'h31;
  localparam logic [6:0] KEY_STAR = 7'h2A;
  localparam logic [6:0] KEY_ZERO = 7'h30;
  localparam logic [6:0] KEY_HASH = 7'h23;
  localparam logic [6:0] KEY_A    = 7'h41;
  localparam logic [6:0] KEY_NONE = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_CALC,
    ST_FINISH
  } bht_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic load;
    logic step;
    logic finish;
  } bht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_step;
    logic out_free;
  } bht_status_t;

  // Key character of keypad button idx
  function automatic logic [6:0] key_of(input logic [3:0] idx);
    logic [6:0] code;
    if (idx inside {[4'd0:4'd8]}) begin
      code = KEY_ONE + {3'd0, idx};
    end else begin
      case (idx)
        4'd9:  code = KEY_STAR;
        4'd10: code = KEY_ZERO;
        4'd11: code = KEY_HASH;
        default: code = KEY_A + {3'd0, idx - 4'd12};
      endcase
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/button_hold_tracker.sv
`default_nettype none

// Button hold tracker. Each input item is one tick: four 12-bit analog
// samples, the 16-bit keypad port word and a query (button, period, time).
// All 22 hold counters are updated together, then a 16-step sequence
// computes the queried counter modulo the period one bit a step while it
// scans the keypad release flags for the lowest released key. The result is
// registered after the update, load, 16 modulo steps and finish, and no new
// item is taken before that. The next item is taken the cycle after the
// result is registered, even while it waits on out_stall.
// Thresholds are written on the cfg channel (index 0 low, 1 high; others are
// ignored) and reset to 100 and 1000. Counters clear at reset.
module button_hold_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // Input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_x_sample,
  input  wire logic [11:0] in_y_sample,
  input  wire logic [11:0] in_a_sample,
  input  wire logic [11:0] in_b_sample,
  input  wire logic [15:0] in_port_bits,
  input  wire logic [4:0]  in_query_button,
  input  wire logic [15:0] in_query_period,
  input  wire logic [15:0] in_query_time,
  // Result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_pressed,
  output logic             out_is_released,
  output logic             out_held_match,
  output logic             out_repeat_hit,
  output logic [15:0]      out_time_held,
  output logic [6:0]       out_key_code
);

  logic [11:0] low_threshold_r, high_threshold_r;
  bht_pkg::bht_cmd_t    cmd;
  bht_pkg::bht_status_t status;

  assign cfg_ready = 1'b1;

  // Hold thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_threshold_r  <= bht_pkg::LOW_THRESHOLD_RESET;
      high_threshold_r <= bht_pkg::HIGH_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bht_pkg::REG_LOW_THRESHOLD:  low_threshold_r  <= cfg_data;
        bht_pkg::REG_HIGH_THRESHOLD: high_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bht_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .low_threshold  (low_threshold_r),
    .high_threshold (high_threshold_r),
    .x_sample       (in_x_sample),
    .y_sample       (in_y_sample),
    .a_sample       (in_a_sample),
    .b_sample       (in_b_sample),
    .port_bits      (in_port_bits),
    .query_button   (in_query_button),
    .query_period   (in_query_period),
    .query_time     (in_query_time),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .is_pressed     (out_is_pressed),
    .is_released    (out_is_released),
    .held_match     (out_held_match),
    .repeat_hit     (out_repeat_hit),
    .time_held      (out_time_held),
    .key_code       (out_key_code)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bht_ctrl.sv
`default_nettype none

module bht_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bht_pkg::bht_status_t status,
  output bht_pkg::bht_cmd_t         cmd
);

  bht_pkg::bht_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through capture, update, load, 16 steps and finish
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bht_pkg::ST_IDLE:   if (in_valid) state_nxt = bht_pkg::ST_UPDATE;
      bht_pkg::ST_UPDATE: state_nxt = bht_pkg::ST_LOAD;
      bht_pkg::ST_LOAD:   state_nxt = bht_pkg::ST_CALC;
      bht_pkg::ST_CALC:   if (status.last_step) state_nxt = bht_pkg::ST_FINISH;
      bht_pkg::ST_FINISH: if (status.out_free) state_nxt = bht_pkg::ST_IDLE;
      default:            state_nxt = bht_pkg::ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      bht_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      bht_pkg::ST_UPDATE: cmd.update = 1'b1;
      bht_pkg::ST_LOAD:   cmd.load   = 1'b1;
      bht_pkg::ST_CALC:   cmd.step   = 1'b1;
      bht_pkg::ST_FINISH: cmd.finish = status.out_free;
      default:            cmd        = '0;
    endcase
  end

  `include "button_hold_tracker_macros.svh"

  `BHT_ASSERT_NEXT(a_accept_to_update, in_valid && !in_stall, state_r == bht_pkg::ST_UPDATE, "accepted item did not start update")
  `BHT_ASSERT_NEXT(a_last_to_finish, (state_r == bht_pkg::ST_CALC) && status.last_step, state_r == bht_pkg::ST_FINISH, "last step did not lead to finish")
  `BHT_ASSERT_NOW(a_single_cmd, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule

`default_nettype wire

FILE: rtl/core/bht_datapath.sv
`default_nettype none

module bht_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bht_pkg::bht_cmd_t    cmd,
  output bht_pkg::bht_status_t      status,
  input  wire logic [11:0]          low_threshold,
  input  wire logic [11:0]          high_threshold,
  input  wire logic [11:0]          x_sample,
  input  wire logic [11:0]          y_sample,
  input  wire logic [11:0]          a_sample,
  input  wire logic [11:0]          b_sample,
  input  wire logic [15:0]          port_bits,
  input  wire logic [4:0]           query_button,
  input  wire logic [15:0]          query_period,
  input  wire logic [15:0]          query_time,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      is_pressed,
  output logic                      is_released,
  output logic                      held_match,
  output logic                      repeat_hit,
  output logic [15:0]               time_held,
  output logic [6:0]                key_code
);

  localparam int unsigned NB = bht_pkg::BUTTON_COUNT;
  localparam int unsigned NK = bht_pkg::KEYPAD_COUNT;

  // Captured item
  logic [11:0] x_r, y_r, a_r, b_r;
  logic [15:0] port_r, period_r, qtime_r;
  logic [4:0]  qb_r;

  // Hold counters and keypad release flags
  logic [15:0] cnt_r [NB];
  logic [15:0] cnt_nxt [NB];
  logic [NK-1:0] rel_r;
  logic [NB-1:0] down;

  // Query and modulo unit
  logic [15:0] c_r, div_r;
  logic [16:0] rem_r, rem_shift;
  logic [3:0]  step_r;
  logic        found_r;
  logic [6:0]  key_r;
  logic        rep;

  logic out_valid_r;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r      <= x_sample;
      y_r      <= y_sample;
      a_r      <= a_sample;
      b_r      <= b_sample;
      port_r   <= port_bits;
      qb_r     <= query_button;
      period_r <= query_period;
      qtime_r  <= query_time;
    end
  end

  // Decode which buttons are down
  always_comb begin
    down[NK-1:0] = ~port_r ^ bht_pkg::ACTIVE_HIGH_MASK;
    down[16]     = (a_r == 12'd0);
    down[17]     = (b_r == 12'd0);
    down[18]     = (y_r < low_threshold);
    down[19]     = (y_r > high_threshold);
    down[20]     = (x_r > high_threshold);
    down[21]     = (x_r < low_threshold);
  end

  // Next counter values, one per button
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (down[i]) begin
        if (cnt_r[i] < bht_pkg::COUNT_MAX) begin
          cnt_nxt[i] = cnt_r[i] + 16'd1;
        end else if (cnt_r[i] == bht_pkg::RELEASE_MARK) begin
          cnt_nxt[i] = 16'd1;
        end
      end else if (cnt_r[i] != 16'd0) begin
        cnt_nxt[i] = (cnt_r[i] == bht_pkg::RELEASE_MARK) ? 16'd0 : bht_pkg::RELEASE_MARK;
      end
    end
  end

  // Update all counters and note released keypad buttons
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        cnt_r[i] <= 16'd0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < NB; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < NK; i++) begin
        rel_r[i] <= (cnt_nxt[i] == bht_pkg::RELEASE_MARK);
      end
    end
  end

  // Shift in the next dividend bit
  assign rem_shift = {rem_r[15:0], div_r[15]};

  // Load the query, then run one modulo bit and one scan entry per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r     <= (qb_r < 5'(NB)) ? cnt_r[qb_r] : 16'd0;
      div_r   <= (qb_r < 5'(NB)) ? cnt_r[qb_r] : 16'd0;
      rem_r   <= 17'd0;
      step_r  <= 4'd0;
      found_r <= 1'b0;
      key_r   <= bht_pkg::KEY_NONE;
    end else if (cmd.step) begin
      div_r  <= {div_r[14:0], 1'b0};
      rem_r  <= (rem_shift >= {1'b0, period_r}) ? rem_shift - {1'b0, period_r} : rem_shift;
      step_r <= step_r + 4'd1;
      if (!found_r && rel_r[step_r]) begin
        found_r <= 1'b1;
        key_r   <= bht_pkg::key_of(step_r);
      end
    end
  end

  assign rep = (c_r != 16'd0) && (c_r != bht_pkg::RELEASE_MARK) &&
               ((period_r <= 16'd1) || (rem_r == 17'd1));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_pressed  <= (c_r == 16'd1);
      is_released <= (c_r == bht_pkg::RELEASE_MARK);
      held_match  <= ({1'b0, c_r} == ({1'b0, qtime_r} + 17'd1));
      repeat_hit  <= rep;
      time_held   <= (c_r == bht_pkg::RELEASE_MARK) ? 16'd0 : c_r;
      key_code    <= key_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.last_step = (step_r == 4'd15);
  assign status.out_free  = !out_valid_r || !out_stall;

  `include "button_hold_tracker_macros.svh"

  `BHT_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, out_valid_r, "finish did not present a result")
  `BHT_ASSERT_NOW(a_repeat_needs_hold, out_valid_r && repeat_hit, time_held != 16'd0, "repeat flagged on idle button")
  `BHT_ASSERT_NOW(a_key_needs_found, !found_r && (cmd.step || cmd.finish), key_r == bht_pkg::KEY_NONE, "key code set without a released button")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned NUM_ROWS       = 19;

  localparam logic [1:0]  REG_SPARE_2 = 2'd2;
  localparam logic [1:0]  REG_SPARE_3 = 2'd3;
  localparam logic [15:0] IDLE_PORT   = 16'hBFFF;
  localparam logic [11:0] MID_SAMPLE  = 12'd500;
  localparam logic [11:0] MAX_SAMPLE  = 12'hFFF;

  localparam int ZONE_MID  = 0;
  localparam int ZONE_LOW  = 1;
  localparam int ZONE_HIGH = 2;
  // Marks a threshold that is drawn at random for the phase
  localparam int RANDOM_THR = -1;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] a;
    logic [11:0] b;
    logic [15:0] port;
    logic [4:0]  qbtn;
    logic [15:0] period;
    logic [15:0] qtime;
  } tick_t;

  typedef struct packed {
    logic        pressed;
    logic        released;
    logic        held;
    logic        rep;
    logic [15:0] held_time;
    logic [6:0]  key;
  } answer_t;

  typedef struct packed {
    tick_t   tick;
    logic    known;
    answer_t ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_x_sample = '0;
  logic [11:0] in_y_sample = '0;
  logic [11:0] in_a_sample = '0;
  logic [11:0] in_b_sample = '0;
  logic [15:0] in_port_bits = '0;
  logic [4:0]  in_query_button = '0;
  logic [15:0] in_query_period = '0;
  logic [15:0] in_query_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_pressed;
  logic        out_is_released;
  logic        out_held_match;
  logic        out_repeat_hit;
  logic [15:0] out_time_held;
  logic [6:0]  out_key_code;

  // Predictor state: counters and thresholds as the block should hold them
  logic [15:0] hold_count [bht_pkg::BUTTON_COUNT];
  logic [11:0] thr_low;
  logic [11:0] thr_high;
  answer_t     expected_answers [$];

  // Random stimulus state: which buttons the operator is holding
  logic [15:0] held_keys = '0;
  logic        a_down = 1'b0;
  logic        b_down = 1'b0;
  int          x_zone = ZONE_MID;
  int          y_zone = ZONE_MID;

  bit          bursts_on = 1'b1;
  bit          failed = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  row_t directed_rows [NUM_ROWS];
  int   phase_low  [PHASES] = '{0, 4095, 4095, 0, RANDOM_THR, RANDOM_THR, RANDOM_THR, 100};
  int   phase_high [PHASES] = '{0, 4095, 0, 4095, RANDOM_THR, RANDOM_THR, RANDOM_THR, 1000};

  button_hold_tracker i_dut (.*);

  always #2 clk = ~clk;

  // Update every counter for one tick and answer the query from the new values
  function automatic answer_t tick_counters(input tick_t t);
    answer_t     r;
    logic        down;
    logic [15:0] c;
    int          i;
    r = '0;
    for (i = 0; i < bht_pkg::BUTTON_COUNT; i++) begin
      if (i < bht_pkg::KEYPAD_COUNT) begin
        down = bht_pkg::ACTIVE_HIGH_MASK[i] ? t.port[i] : !t.port[i];
      end else begin
        case (i)
          16: down = (t.a == 0);
          17: down = (t.b == 0);
          18: down = (t.y < thr_low);
          19: down = (t.y > thr_high);
          20: down = (t.x > thr_high);
          default: down = (t.x < thr_low);
        endcase
      end
      if (down) begin
        if (hold_count[i] < bht_pkg::COUNT_MAX) hold_count[i] = hold_count[i] + 16'd1;
        else if (hold_count[i] == bht_pkg::RELEASE_MARK) hold_count[i] = 16'd1;
      end else if (hold_count[i] != 0) begin
        hold_count[i] = (hold_count[i] == bht_pkg::RELEASE_MARK) ? 16'd0
                                                                 : bht_pkg::RELEASE_MARK;
      end
    end
    c = (t.qbtn < bht_pkg::BUTTON_COUNT) ? hold_count[t.qbtn] : 16'd0;
    r.pressed   = (c == 16'd1);
    r.released  = (c == bht_pkg::RELEASE_MARK);
    r.held      = ({1'b0, c} == ({1'b0, t.qtime} + 17'd1));
    if (c == 0 || c == bht_pkg::RELEASE_MARK) r.rep = 1'b0;
    else if (t.period <= 1) r.rep = 1'b1;
    else r.rep = ((c % t.period) == 16'd1);
    r.held_time = r.released ? 16'd0 : c;
    // Walk down so that the lowest released key wins
    r.key = bht_pkg::KEY_NONE;
    for (i = bht_pkg::KEYPAD_COUNT - 1; i >= 0; i--) begin
      if (hold_count[i] == bht_pkg::RELEASE_MARK) begin
        if (i < 9) r.key = 7'(bht_pkg::KEY_ONE + i);
        else if (i == 9) r.key = bht_pkg::KEY_STAR;
        else if (i == 10) r.key = bht_pkg::KEY_ZERO;
        else if (i == 11) r.key = bht_pkg::KEY_HASH;
        else r.key = 7'(bht_pkg::KEY_A + (i - 12));
      end
    end
    return r;
  endfunction

  // Draw a sample inside the wanted joystick zone under the current thresholds
  function automatic logic [11:0] zone_sample(input int zone);
    logic [11:0] s;
    s = 12'($urandom);
    case (zone)
      ZONE_LOW:  if (thr_low != 0) s = 12'($urandom_range(thr_low - 1, 0));
      ZONE_HIGH: if (thr_high != MAX_SAMPLE) s = 12'($urandom_range(MAX_SAMPLE, thr_high + 1));
      default:   if (thr_low <= thr_high) s = 12'($urandom_range(thr_high, thr_low));
    endcase
    return s;
  endfunction

  // Build one random tick: mostly held-button sequences, some pure noise
  task automatic make_tick(output tick_t t);
    int i;
    if ($urandom_range(0, 9) == 0) begin
      t = tick_t'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      for (i = 0; i < bht_pkg::KEYPAD_COUNT; i++)
        if ($urandom_range(0, 19) == 0) held_keys[i] = ~held_keys[i];
      if ($urandom_range(0, 19) == 0) a_down = ~a_down;
      if ($urandom_range(0, 19) == 0) b_down = ~b_down;
      if ($urandom_range(0, 19) == 0) x_zone = $urandom_range(ZONE_HIGH, ZONE_MID);
      if ($urandom_range(0, 19) == 0) y_zone = $urandom_range(ZONE_HIGH, ZONE_MID);
      t.port = ~held_keys ^ bht_pkg::ACTIVE_HIGH_MASK;
      t.a = a_down ? 12'd0 : 12'($urandom_range(4095, 1));
      t.b = b_down ? 12'd0 : 12'($urandom_range(4095, 1));
      t.x = zone_sample(x_zone);
      t.y = zone_sample(y_zone);
      t.qbtn = ($urandom_range(0, 15) == 0)
               ? 5'($urandom_range(31, bht_pkg::BUTTON_COUNT))
               : 5'($urandom_range(bht_pkg::BUTTON_COUNT - 1, 0));
      case ($urandom_range(0, 9))
        0: t.period = 16'd0;
        1: t.period = 16'd1;
        2, 3, 4, 5, 6: t.period = 16'($urandom_range(8, 2));
        7: t.period = 16'($urandom_range(40, 9));
        8: t.period = 16'hFFFF;
        default: t.period = 16'($urandom);
      endcase
      case ($urandom_range(0, 11))
        0: t.qtime = bht_pkg::COUNT_MAX;
        1: t.qtime = bht_pkg::RELEASE_MARK;
        2: t.qtime = 16'($urandom);
        default: t.qtime = 16'($urandom_range(40, 0));
      endcase
    end
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_tick(input tick_t t, input logic known, input answer_t typed);
    answer_t predicted;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_x_sample     <= t.x;
    in_y_sample     <= t.y;
    in_a_sample     <= t.a;
    in_b_sample     <= t.b;
    in_port_bits    <= t.port;
    in_query_button <= t.qbtn;
    in_query_period <= t.period;
    in_query_time   <= t.qtime;
    do @(posedge clk); while (in_stall);
    predicted = tick_counters(t);
    expected_answers.push_back(known ? typed : predicted);
    @(negedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bht_pkg::REG_LOW_THRESHOLD) thr_low = val;
    else if (idx == bht_pkg::REG_HIGH_THRESHOLD) thr_high = val;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_answers.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(18, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result item with none expected", $time);
        failed = 1'b1;
      end else begin
        want = expected_answers.pop_front();
        compare_field("is_pressed", want.pressed, out_is_pressed);
        compare_field("is_released", want.released, out_is_released);
        compare_field("held_match", want.held, out_held_match);
        compare_field("repeat_hit", want.rep, out_repeat_hit);
        compare_field("time_held", want.held_time, out_time_held);
        compare_field("key_code", want.key, out_key_code);
      end
    end
  end

  // Give up when no channel has moved an item for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    tick_t       t;
    logic [11:0] lo;
    logic [11:0] hi;
    int          ph;
    int          n;
    int          r;

    // Directed ticks under the reset thresholds
    directed_rows = '{
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd0, 16'd0, 16'd0},
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, bht_pkg::KEY_NONE}},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, 16'hBFFE, 5'd0, 16'd0, 16'd0},
        1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 16'd1, bht_pkg::KEY_NONE}},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, 16'hBFFE, 5'd0, 16'd2, 16'd1},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, 16'hBFFE, 5'd0, 16'd3, 16'd5},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd0, 16'd0, bht_pkg::COUNT_MAX},
        1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 16'd0, bht_pkg::KEY_ONE}},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd0, 16'd0,
          bht_pkg::RELEASE_MARK},
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, bht_pkg::KEY_NONE}},
      '{'{12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 5'd21, 16'd0, 16'd0},
        1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 16'd1, bht_pkg::KEY_NONE}},
      '{'{12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 5'd18, 16'd0, 16'd1},
        1'b0, '0},
      '{'{MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 16'hFFFF, 5'd14, 16'd0, 16'd0},
        1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 16'd1, bht_pkg::KEY_ONE}},
      '{'{MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 16'hFFFF, 5'd22, 16'd0,
          bht_pkg::RELEASE_MARK},
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, bht_pkg::KEY_NONE}},
      '{'{MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 16'hFFFF, 5'd31, 16'd0, 16'd0},
        1'b0, '0},
      '{'{MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 16'hFFFF, 5'd19, 16'hFFFF, 16'd2},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, 16'h7FFF, 5'd14, 16'd0, 16'd0},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd15, 16'd0, bht_pkg::COUNT_MAX},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd0, 12'd0, IDLE_PORT, 5'd16, 16'd1, 16'd0},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd0, 12'd0, IDLE_PORT, 5'd17, 16'd1, 16'd0},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, 16'hB1FF, 5'd9, 16'd2, 16'd0},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd11, 16'd0, bht_pkg::COUNT_MAX},
        1'b0, '0},
      '{'{MID_SAMPLE, MID_SAMPLE, 12'd1, 12'd1, IDLE_PORT, 5'd10, 16'd0, 16'd0},
        1'b0, '0}
    };

    // Reset the predictor alongside the block
    for (r = 0; r < bht_pkg::BUTTON_COUNT; r++) hold_count[r] = 16'd0;
    thr_low  = bht_pkg::LOW_THRESHOLD_RESET;
    thr_high = bht_pkg::HIGH_THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < NUM_ROWS; r++)
      send_tick(directed_rows[r].tick, directed_rows[r].known, directed_rows[r].ans);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own pair of thresholds
    for (ph = 0; ph < PHASES; ph++) begin
      lo = (phase_low[ph] == RANDOM_THR) ? 12'($urandom) : 12'(phase_low[ph]);
      hi = (phase_high[ph] == RANDOM_THR) ? 12'($urandom) : 12'(phase_high[ph]);
      write_reg(REG_SPARE_2, 12'($urandom));
      write_reg(bht_pkg::REG_LOW_THRESHOLD, lo);
      write_reg(bht_pkg::REG_HIGH_THRESHOLD, hi);
      write_reg(REG_SPARE_3, 12'($urandom));
      cfg_valid <= 1'b0;
      if (ph == PHASES - 1) bursts_on = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        make_tick(t);
        send_tick(t, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
